// ----- hdl/cga_pkg.sv -----
// Shared constants, word type and saturation helper for the complex Gram accumulator.
package cga_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_SIZE_DEF = 64;
    localparam int SLICES_DEF   = 16;
    localparam int DECIMATE_DEF = 8;
    // 1/17 in Q16
    localparam int INV17_Q16    = 3855;

    typedef logic signed [DATA_W-1:0] t_word;

    // clamp a 33-bit signed sum to 32 bits
    function automatic t_word sat33(input logic signed [DATA_W:0] v);
        t_word r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/cga_if.sv -----
// Request and result channel interfaces of the complex Gram accumulator.
interface cga_in_if;
    logic                 valid;
    logic                 ready;
    cga_pkg::t_word       rr_sum;
    cga_pkg::t_word       ii_sum;
    cga_pkg::t_word       ri_sum;
    cga_pkg::t_word       ir_sum;
    logic [5:0]           row_index;
    logic [5:0]           col_index;
    logic [3:0]           slice_index;
    logic [4:0]           group_index;
    modport source(output valid, rr_sum, ii_sum, ri_sum, ir_sum, row_index, col_index,
                   slice_index, group_index, input ready);
    modport sink(input valid, rr_sum, ii_sum, ri_sum, ir_sum, row_index, col_index,
                 slice_index, group_index, output ready);
endinterface

interface cga_out_if;
    logic                 valid;
    logic                 ready;
    cga_pkg::t_word       power_avg;
    cga_pkg::t_word       real_avg;
    cga_pkg::t_word       imag_avg;
    logic                 total_valid;
    cga_pkg::t_word       group_total;
    logic                 coarse_valid;
    cga_pkg::t_word       coarse_total;
    modport source(output valid, power_avg, real_avg, imag_avg, total_valid, group_total,
                   coarse_valid, coarse_total, input ready);
    modport sink(input valid, power_avg, real_avg, imag_avg, total_valid, group_total,
                 coarse_valid, coarse_total, output ready);
endinterface

// ----- hdl/cga_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module cga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/complex_gram_average_accumulate.sv -----
// Complex Gram accumulator: one request per cycle while the output is not stalled.
// The block takes one request every cycle while the output is not stalled and returns
// one result for each. Each request reads its accumulators once, at acceptance, from a
// 96-bit store (power, real, imaginary), a fine total store and a coarse total store;
// the accumulators are written back from stage three and the totals from stage four,
// and writebacks are forwarded to younger requests at the same entry.
// Stores come up undefined and are not cleared: slice 0 and group 0 start them afresh.
module complex_gram_average_accumulate #(
    parameter int MAX_SIZE = cga_pkg::MAX_SIZE_DEF,
    parameter int SLICES   = cga_pkg::SLICES_DEF,
    parameter int DECIMATE = cga_pkg::DECIMATE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cga_in_if.sink     i_in,
    cga_out_if.source  o_out
);

    localparam int DW     = cga_pkg::DATA_W;
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CDIM   = (MAX_SIZE + DECIMATE - 1) / DECIMATE;
    localparam int CDEPTH = CDIM * CDIM;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    typedef cga_pkg::t_word t_word;

    // request decode
    logic [5:0]     in_row, in_col;
    logic [AW-1:0]  in_addr;
    logic [CAW-1:0] in_caddr;
    logic           in_last, in_coarse;
    logic           advance, accept;

    assign in_row    = 6'(int'(i_in.row_index) % MAX_SIZE);
    assign in_col    = 6'(int'(i_in.col_index) % MAX_SIZE);
    assign in_addr   = AW'(int'(in_row) * MAX_SIZE + int'(in_col));
    assign in_caddr  = CAW'((int'(in_row) / DECIMATE) * CDIM + int'(in_col) / DECIMATE);
    assign in_last   = (int'(i_in.slice_index) == SLICES - 1);
    assign in_coarse = in_last && ((int'(in_row) % DECIMATE) == 0)
                       && ((int'(in_col) % DECIMATE) == 0);

    logic r_ov;
    assign advance    = !r_ov || o_out.ready;
    assign accept     = i_in.valid && advance;
    assign i_in.ready = advance;

    // memories
    logic             acc_we, tot_we, crs_we;
    logic [AW-1:0]    tot_waddr;
    logic [CAW-1:0]   crs_waddr;
    logic [AW-1:0]    acc_waddr;
    logic [3*DW-1:0]  acc_wdata, acc_rdata;
    t_word            tot_wdata, crs_wdata, tot_rdata, crs_rdata;

    cga_ram #(.WIDTH(3*DW), .DEPTH(DEPTH)) u_acc_ram (
        .i_clk(i_clk), .i_we(acc_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_re(advance), .i_raddr(in_addr), .o_rdata(acc_rdata)
    );
    cga_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_tot_ram (
        .i_clk(i_clk), .i_we(tot_we), .i_waddr(tot_waddr), .i_wdata(tot_wdata),
        .i_re(advance), .i_raddr(in_addr), .o_rdata(tot_rdata)
    );
    cga_ram #(.WIDTH(DW), .DEPTH(CDEPTH)) u_crs_ram (
        .i_clk(i_clk), .i_we(crs_we), .i_waddr(crs_waddr), .i_wdata(crs_wdata),
        .i_re(advance), .i_raddr(in_caddr), .o_rdata(crs_rdata)
    );

    // pipeline registers
    logic r_v1, r_v2, r_v3, r_v4;

    t_word           r1_rr, r1_ii, r1_ri, r1_ir;
    logic [AW-1:0]   r1_addr, r2_addr, r3_addr, r4_addr;
    logic [CAW-1:0]  r1_caddr, r2_caddr, r3_caddr, r4_caddr;
    logic            r1_below;
    logic            r1_slice0, r2_slice0, r3_slice0;
    logic            r1_group0, r2_group0, r3_group0, r4_group0;
    logic            r1_last, r2_last, r3_last, r4_last;
    logic            r1_coarse, r2_coarse, r3_coarse, r4_coarse;
    logic            r1_afwd, r1_tfwd, r1_cfwd;
    logic [3*DW-1:0] r1_aold, r2_aold, r3_aold;
    t_word           r1_told, r2_told, r3_told, r4_told;
    t_word           r1_cold, r2_cold, r3_cold, r4_cold;
    t_word           r2_re, r2_im, r3_re, r3_im;
    logic [2*DW-1:0] r3_sqr, r3_sqi;
    t_word           r4_pa, r4_ra, r4_ia;

    t_word           r_o_power, r_o_real, r_o_imag, r_o_total, r_o_coarse;
    logic            r_o_tvalid, r_o_cvalid;

    // stage 1: form re and im, merge read data with forwarded writes
    logic [3*DW-1:0] eff1_a;
    t_word           eff1_t, eff1_c, s1_re, s1_im0, s1_im;

    assign eff1_a = r1_afwd ? r1_aold : acc_rdata;
    assign eff1_t = r1_tfwd ? r1_told : tot_rdata;
    assign eff1_c = r1_cfwd ? r1_cold : crs_rdata;
    assign s1_re  = cga_pkg::sat33({r1_rr[DW-1], r1_rr} + {r1_ii[DW-1], r1_ii});
    assign s1_im0 = cga_pkg::sat33({r1_ri[DW-1], r1_ri} - {r1_ir[DW-1], r1_ir});
    assign s1_im  = r1_below ? cga_pkg::sat33(-{s1_im0[DW-1], s1_im0}) : s1_im0;

    // stage 2: squared magnitudes
    logic [DW-1:0] abs_re, abs_im;
    assign abs_re = r2_re[DW-1] ? (~r2_re + 1'b1) : r2_re;
    assign abs_im = r2_im[DW-1] ? (~r2_im + 1'b1) : r2_im;

    // stage 3: accumulate and write back
    logic [2*DW-1:0] sqsum;
    logic [2*DW-21:0] pw;
    t_word           pterm, rterm, iterm, p0, rv0, iv0, s3_pa, s3_ra, s3_ia;

    assign sqsum = r3_sqr + r3_sqi;
    assign pw    = sqsum[2*DW-1:20];
    assign pterm = (|pw[2*DW-21:DW-1]) ? {1'b0, {(DW-1){1'b1}}} : {1'b0, pw[DW-2:0]};
    assign rterm = r3_re >>> 4;
    assign iterm = r3_im >>> 4;
    assign p0    = r3_slice0 ? '0 : r3_aold[3*DW-1:2*DW];
    assign rv0   = r3_slice0 ? '0 : r3_aold[2*DW-1:DW];
    assign iv0   = r3_slice0 ? '0 : r3_aold[DW-1:0];
    assign s3_pa = cga_pkg::sat33({p0[DW-1], p0} + {1'b0, pterm});
    assign s3_ra = cga_pkg::sat33({rv0[DW-1], rv0} + {rterm[DW-1], rterm});
    assign s3_ia = cga_pkg::sat33({iv0[DW-1], iv0} + {iterm[DW-1], iterm});

    assign acc_we    = advance && r_v3;
    assign acc_waddr = r3_addr;
    assign acc_wdata = {s3_pa, s3_ra, s3_ia};

    // stage 4: power over seventeen, totals
    logic signed [DW+12:0] prod;
    logic signed [DW-4:0]  add17;
    t_word                 t0, c0;

    assign prod  = $signed({{13{r4_pa[DW-1]}}, r4_pa}) * (DW+13)'(cga_pkg::INV17_Q16);
    assign add17 = prod[DW+12:16];
    assign t0    = r4_group0 ? '0 : r4_told;
    assign c0    = r4_group0 ? '0 : r4_cold;

    assign tot_we    = advance && r_v4 && r4_last;
    assign tot_waddr = r4_addr;
    assign tot_wdata = cga_pkg::sat33({t0[DW-1], t0} + {{4{add17[DW-4]}}, add17});
    assign crs_we    = advance && r_v4 && r4_coarse;
    assign crs_waddr = r4_caddr;
    assign crs_wdata = cga_pkg::sat33({c0[DW-1], c0} + {{4{add17[DW-4]}}, add17});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (advance) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_rr     <= i_in.rr_sum;
            r1_ii     <= i_in.ii_sum;
            r1_ri     <= i_in.ri_sum;
            r1_ir     <= i_in.ir_sum;
            r1_addr   <= in_addr;
            r1_caddr  <= in_caddr;
            r1_below  <= in_col < in_row;
            r1_slice0 <= i_in.slice_index == '0;
            r1_group0 <= i_in.group_index == '0;
            r1_last   <= in_last;
            r1_coarse <= in_coarse;
            // a writeback in the read cycle is not seen by the read port
            r1_afwd   <= acc_we && (acc_waddr == in_addr);
            r1_aold   <= acc_wdata;
            r1_tfwd   <= tot_we && (tot_waddr == in_addr);
            r1_told   <= tot_wdata;
            r1_cfwd   <= crs_we && (crs_waddr == in_caddr);
            r1_cold   <= crs_wdata;

            r2_re     <= s1_re;
            r2_im     <= s1_im;
            r2_addr   <= r1_addr;
            r2_caddr  <= r1_caddr;
            r2_slice0 <= r1_slice0;
            r2_group0 <= r1_group0;
            r2_last   <= r1_last;
            r2_coarse <= r1_coarse;
            r2_aold   <= (acc_we && acc_waddr == r1_addr) ? acc_wdata : eff1_a;
            r2_told   <= (tot_we && tot_waddr == r1_addr) ? tot_wdata : eff1_t;
            r2_cold   <= (crs_we && crs_waddr == r1_caddr) ? crs_wdata : eff1_c;

            r3_sqr    <= abs_re * abs_re;
            r3_sqi    <= abs_im * abs_im;
            r3_re     <= r2_re;
            r3_im     <= r2_im;
            r3_addr   <= r2_addr;
            r3_caddr  <= r2_caddr;
            r3_slice0 <= r2_slice0;
            r3_group0 <= r2_group0;
            r3_last   <= r2_last;
            r3_coarse <= r2_coarse;
            r3_aold   <= (acc_we && acc_waddr == r2_addr) ? acc_wdata : r2_aold;
            r3_told   <= (tot_we && tot_waddr == r2_addr) ? tot_wdata : r2_told;
            r3_cold   <= (crs_we && crs_waddr == r2_caddr) ? crs_wdata : r2_cold;

            r4_pa     <= s3_pa;
            r4_ra     <= s3_ra;
            r4_ia     <= s3_ia;
            r4_addr   <= r3_addr;
            r4_caddr  <= r3_caddr;
            r4_group0 <= r3_group0;
            r4_last   <= r3_last;
            r4_coarse <= r3_coarse;
            r4_told   <= (tot_we && tot_waddr == r3_addr) ? tot_wdata : r3_told;
            r4_cold   <= (crs_we && crs_waddr == r3_caddr) ? crs_wdata : r3_cold;

            r_o_power  <= r4_pa;
            r_o_real   <= r4_ra;
            r_o_imag   <= r4_ia;
            r_o_tvalid <= r4_last;
            r_o_total  <= r4_last ? tot_wdata : '0;
            r_o_cvalid <= r4_coarse;
            r_o_coarse <= r4_coarse ? crs_wdata : '0;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.power_avg    = r_o_power;
    assign o_out.real_avg     = r_o_real;
    assign o_out.imag_avg     = r_o_imag;
    assign o_out.total_valid  = r_o_tvalid;
    assign o_out.group_total  = r_o_total;
    assign o_out.coarse_valid = r_o_cvalid;
    assign o_out.coarse_total = r_o_coarse;

    a_tot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.total_valid |-> o_out.group_total == '0)
        else $error("group total nonzero without total_valid");
    a_coarse_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.coarse_valid |-> o_out.total_valid)
        else $error("coarse update outside last slice");
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("accepted request lost at stage one");
    // bubbles may carry unknown data, so only a live stage four is compared
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_v4) && (!r_v4 || $stable(r4_pa)))
        else $error("pipeline moved during stall");

endmodule
